FILE: design/ttd_pkg.sv
package ttd_pkg;

  localparam int TASK_SLOTS_DEF = 4;
  localparam int TICK_W         = 16;
  localparam int CFG_W          = 3;
  localparam int SLOT_W         = 2;

  typedef enum logic {
    OP_POLL   = 1'b0,
    OP_FINISH = 1'b1
  } opcode_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // latch the accepted item, clear scan result
    logic write_slot;  // reschedule the finished slot
    logic clr_idx;
    logic inc_idx;
    logic mark;        // finish scan: flag the current slot if inside the window
    logic capture;     // poll scan: record the current slot as the answer
    logic load_out;    // move the answer into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_finish;
    logic slot_ok;     // finished slot is below the active count
    logic cnt_zero;
    logic last;        // scan index is at the last active slot
    logic hit;         // current slot is missed or due at the polled tick
  } sts_t;

endpackage

FILE: design/ttd_ctrl.sv
module ttd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ttd_pkg::sts_t sts,
  output ttd_pkg::cmd_t cmd
);
  import ttd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_finish) begin
          if (sts.slot_ok) begin
            cmd.write_slot = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_EMIT;
          end
        end else if (sts.cnt_zero) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.is_finish) begin
          cmd.mark = 1'b1;
          if (sts.last) state_nxt = S_EMIT;
          else          cmd.inc_idx = 1'b1;
        end else if (sts.hit) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EMIT;
        end else if (sts.last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_EMIT: begin
        // hold the answer until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ready) |=> (state_r == S_EMIT))
    else $error("left emit state while output blocked");
`endif

endmodule

FILE: design/ttd_datapath.sv
module ttd_datapath #(
  parameter int TASK_SLOTS = ttd_pkg::TASK_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ttd_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_opcode,
  input  logic [ttd_pkg::SLOT_W-1:0] in_task_index,
  input  logic [ttd_pkg::TICK_W-1:0] in_from_tick,
  input  logic [ttd_pkg::TICK_W-1:0] in_to_tick,
  input  logic [ttd_pkg::TICK_W-1:0] in_delay_ticks,
  output logic                       out_task_found,
  output logic [ttd_pkg::SLOT_W-1:0] out_chosen_task,
  input  ttd_pkg::cmd_t              cmd,
  output ttd_pkg::sts_t              sts
);
  import ttd_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);

  logic [CFG_W-1:0]  active_r;
  logic              opcode_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TICK_W-1:0] t0_r, t1_r, dly_r;
  logic [IDX_W-1:0]  idx_r;
  logic              res_found_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic [TICK_W-1:0]     due_r [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] missed_r;

  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  slot_idx;
  logic [TICK_W-1:0] cur_due;
  logic              in_win;

  function automatic logic in_window(input logic [TICK_W-1:0] t,
                                     input logic [TICK_W-1:0] lo,
                                     input logic [TICK_W-1:0] hi);
    if (lo <= hi) return (t >= lo) && (t < hi);
    return (t >= lo) || (t < hi);
  endfunction

  assign cnt      = (int'(active_r) > TASK_SLOTS) ? CNT_W'(TASK_SLOTS) : CNT_W'(active_r);
  assign slot_idx = IDX_W'(slot_r);
  assign cur_due  = due_r[idx_r];
  assign in_win   = in_window(cur_due, t0_r, t1_r);

  assign sts.is_finish = (opcode_r == OP_FINISH);
  assign sts.slot_ok   = int'(slot_r) < int'(cnt);
  assign sts.cnt_zero  = (cnt == '0);
  assign sts.last      = int'(idx_r) == int'(cnt) - 1;
  assign sts.hit       = missed_r[idx_r] || (cur_due == t0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      opcode_r <= in_opcode;
      slot_r   <= in_task_index;
      t0_r     <= in_from_tick;
      t1_r     <= in_to_tick;
      dly_r    <= in_delay_ticks;
    end
    if (cmd.clr_idx)      idx_r <= '0;
    else if (cmd.inc_idx) idx_r <= idx_r + 1'b1;
    if (cmd.load_in) begin
      res_found_r <= 1'b0;
      res_slot_r  <= '0;
    end else if (cmd.capture) begin
      res_found_r <= 1'b1;
      res_slot_r  <= SLOT_W'(idx_r);
    end
    if (cmd.load_out) begin
      out_found_r <= res_found_r;
      out_slot_r  <= res_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) due_r[i] <= '0;
      missed_r <= '0;
    end else if (cmd.write_slot) begin
      due_r[slot_idx]    <= t1_r + dly_r;
      missed_r[slot_idx] <= 1'b0;
    end else if (cmd.mark && in_win) begin
      missed_r[idx_r] <= 1'b1;
    end
  end

  assign out_task_found  = out_found_r;
  assign out_chosen_task = out_slot_r;

`ifndef ASSERT_OFF
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mark || cmd.capture) |-> (int'(idx_r) < int'(cnt)))
    else $error("scan index beyond active count");

  a_write_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_slot |-> (sts.slot_ok && sts.is_finish))
    else $error("reschedule of inactive slot");
`endif

endmodule

FILE: design/tick_task_dispatcher_core.sv
// Tick task dispatcher. A poll transfer (opcode 0, in_from_tick = current tick) returns the
// lowest active slot that is missed or due at that tick; a finish transfer (opcode 1)
// reschedules the slot to in_to_tick + delay_ticks and flags every active slot whose due
// tick falls in [in_from_tick, in_to_tick), wrapping through zero. Each transfer gives one
// result; finish results and empty polls read found = 0, slot 0. After acceptance the item
// passes through a decode state, a scan state that visits the active slots (all active slots
// for a finish, up to the first hit for a poll, none for an ignored finish or an empty slot
// set) and an emit state that loads the output register: a single compare unit visits one
// slot per cycle. The next item can be accepted in the cycle after the output register is
// loaded; a result still waiting in the output register holds the block until
// out_ready frees it. cfg_wdata sets the active slot count; write it only while the block
// is idle.
module tick_task_dispatcher_core #(
  parameter int TASK_SLOTS = ttd_pkg::TASK_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ttd_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [ttd_pkg::SLOT_W-1:0] in_task_index,
  input  logic [ttd_pkg::TICK_W-1:0] in_from_tick,
  input  logic [ttd_pkg::TICK_W-1:0] in_to_tick,
  input  logic [ttd_pkg::TICK_W-1:0] in_delay_ticks,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_task_found,
  output logic [ttd_pkg::SLOT_W-1:0] out_chosen_task
);
  import ttd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ttd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttd_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_task_index   (in_task_index),
    .in_from_tick    (in_from_tick),
    .in_to_tick      (in_to_tick),
    .in_delay_ticks  (in_delay_ticks),
    .out_task_found  (out_task_found),
    .out_chosen_task (out_chosen_task),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: tb/sv/tb_tick_task_dispatcher_core.sv
`timescale 1ns / 100ps

module tb_tick_task_dispatcher_core;
  import ttd_pkg::*;

  localparam int SLOTS      = TASK_SLOTS_DEF;
  localparam int SETTLE_CYC = 12;    // scan of four slots plus output stage, with margin
  localparam int STALL_MAX  = 5000;  // cycles without any transfer before giving up

  typedef struct packed {
    opcode_t           op;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] t0;
    logic [TICK_W-1:0] t1;
    logic [TICK_W-1:0] dly;
  } sched_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = 1'b0;
  logic [SLOT_W-1:0] in_task_index = '0;
  logic [TICK_W-1:0] in_from_tick = '0;
  logic [TICK_W-1:0] in_to_tick = '0;
  logic [TICK_W-1:0] in_delay_ticks = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_task_found;
  logic [SLOT_W-1:0] out_chosen_task;

  sched_item_t item_q[$];
  grant_t      grant_q[$];
  sched_item_t drv_item;
  logic        in_taken = 1'b0;
  int          src_idle = 0;
  int          snk_idle = 0;
  int          err_cnt = 0;
  int          quiet_cyc = 0;

  // scheduler shadow state
  logic [TICK_W-1:0] pred_due[SLOTS];
  logic              pred_missed[SLOTS];
  logic [CFG_W-1:0]  pred_cnt;

  // rough due ticks used only to aim stimulus at interesting ticks
  logic [TICK_W-1:0] aim_due[SLOTS];

  tick_task_dispatcher_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_task_index  (in_task_index),
    .in_from_tick   (in_from_tick),
    .in_to_tick     (in_to_tick),
    .in_delay_ticks (in_delay_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_task_found (out_task_found),
    .out_chosen_task(out_chosen_task)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic in_span(input logic [TICK_W-1:0] t, input logic [TICK_W-1:0] lo,
                                   input logic [TICK_W-1:0] hi);
    if (lo <= hi) return (t >= lo) && (t < hi);
    return (t >= lo) || (t < hi);
  endfunction

  function automatic grant_t dispatch_predict(input sched_item_t it);
    grant_t g;
    int     n;
    int     i;
    g = '0;
    n = (pred_cnt > SLOTS) ? SLOTS : pred_cnt;
    if (it.op == OP_POLL) begin
      // scan downward so the lowest hit wins
      for (i = n - 1; i >= 0; i--) begin
        if (pred_missed[i] || pred_due[i] == it.t0) begin
          g.found = 1'b1;
          g.slot  = SLOT_W'(i);
        end
      end
    end else if (it.slot < n) begin
      pred_missed[it.slot] = 1'b0;
      pred_due[it.slot]    = it.t1 + it.dly;
      for (i = 0; i < n; i++) begin
        if (in_span(pred_due[i], it.t0, it.t1)) pred_missed[i] = 1'b1;
      end
    end
    return g;
  endfunction

  task automatic push_item(input opcode_t op, input int slot, input int t0, input int t1,
                           input int dly);
    sched_item_t it;
    it.op   = op;
    it.slot = SLOT_W'(slot);
    it.t0   = TICK_W'(t0);
    it.t1   = TICK_W'(t1);
    it.dly  = TICK_W'(dly);
    item_q.push_back(it);
  endtask

  task automatic push_random(input int count);
    sched_item_t       it;
    int                r;
    int                k;
    logic [TICK_W-1:0] d;
    for (int c = 0; c < count; c++) begin
      it.slot = SLOT_W'($urandom_range(0, 3));
      it.t0   = TICK_W'($urandom);
      it.t1   = TICK_W'($urandom);
      it.dly  = TICK_W'($urandom);
      d       = aim_due[$urandom_range(0, SLOTS - 1)];
      r       = $urandom_range(0, 99);
      if (r < 10) begin
        it.op = opcode_t'($urandom_range(0, 1));  // noise
      end else if (r < 50) begin
        it.op = OP_POLL;
        if ($urandom_range(0, 9) < 6) it.t0 = d;
      end else begin
        it.op = OP_FINISH;
        k = $urandom_range(0, 9);
        if (k < 5) begin
          it.t0 = TICK_W'(d - $urandom_range(0, 40));
          it.t1 = TICK_W'(d + $urandom_range(1, 40));
        end else if (k < 6) begin
          it.t1 = it.t0;
        end else if (k < 8) begin
          // window wrapping through zero
          it.t0 = TICK_W'(16'hFFFF - $urandom_range(0, 300));
          it.t1 = TICK_W'($urandom_range(0, 300));
        end
        k = $urandom_range(0, 9);
        if (k < 5) it.dly = TICK_W'($urandom_range(0, 60));
        else if (k < 7) it.dly = TICK_W'(16'hFFFF - $urandom_range(0, 40));  // lands back before end
        aim_due[it.slot] = it.t1 + it.dly;
      end
      item_q.push_back(it);
    end
  endtask

  task automatic drain();
    while (item_q.size() != 0 || in_valid || grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (item_q.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
        drv_item = item_q.pop_front();
        in_opcode      <= drv_item.op;
        in_task_index  <= drv_item.slot;
        in_from_tick   <= drv_item.t0;
        in_to_tick     <= drv_item.t1;
        in_delay_ticks <= drv_item.dly;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(0, 99) >= snk_idle);
  end

  // monitor, shadow model and watchdog
  always @(posedge clk) begin
    sched_item_t acc;
    grant_t      exp_g;
    if (!rst_n) begin
      in_taken <= 1'b0;
      pred_cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
        pred_due[i]    = '0;
        pred_missed[i] = 1'b0;
      end
      quiet_cyc = 0;
    end else begin
      in_taken <= in_valid && in_ready;
      quiet_cyc++;
      if (cfg_we) begin
        pred_cnt  = cfg_wdata;
        quiet_cyc = 0;
      end
      if (in_valid && in_ready) begin
        acc.op   = opcode_t'(in_opcode);
        acc.slot = in_task_index;
        acc.t0   = in_from_tick;
        acc.t1   = in_to_tick;
        acc.dly  = in_delay_ticks;
        grant_q.push_back(dispatch_predict(acc));
        quiet_cyc = 0;
      end
      if (out_valid && out_ready) begin
        quiet_cyc = 0;
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b task=%0d",
                                    out_task_found, out_chosen_task));
        end else begin
          exp_g = grant_q.pop_front();
          if (out_task_found !== exp_g.found)
            report_mismatch($sformatf("task_found %0b, expected %0b",
                                      out_task_found, exp_g.found));
          if (out_chosen_task !== exp_g.slot)
            report_mismatch($sformatf("chosen_task %0d, expected %0d",
                                      out_chosen_task, exp_g.slot));
        end
      end
      if (quiet_cyc >= STALL_MAX) begin
        $display("tb_tick_task_dispatcher_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int cfg_seq[5];
    cfg_seq = '{4, 1, 0, 3, 2};
    for (int i = 0; i < SLOTS; i++) aim_due[i] = '0;
    src_idle = 13;
    snk_idle = 56;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset count is zero: nothing is active
    push_item(OP_POLL, 0, 0, 0, 0);
    push_item(OP_FINISH, 2, 0, 16'hFFFF, 5);
    drain();

    write_cfg(4);
    push_item(OP_POLL, 0, 0, 0, 0);                       // all due at tick 0
    push_item(OP_POLL, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // nothing due
    push_item(OP_FINISH, 0, 0, 0, 10);                    // empty window
    push_item(OP_POLL, 0, 0, 0, 0);
    push_item(OP_FINISH, 1, 5, 5, 16'hFFFF);
    push_item(OP_FINISH, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(OP_FINISH, 3, 100, 200, 50);
    push_item(OP_POLL, 0, 10, 0, 0);
    push_item(OP_POLL, 0, 250, 0, 0);
    push_item(OP_FINISH, 3, 16'hFFF0, 8, 0);              // window wraps through zero
    push_item(OP_POLL, 0, 1234, 0, 0);
    push_item(OP_FINISH, 1, 0, 20, 16'hFFF0);             // lands inside its own window
    push_item(OP_POLL, 2, 16'h5555, 16'hAAAA, 16'h5555);
    push_item(OP_FINISH, 0, 3, 3, 0);
    push_item(OP_POLL, 0, 7, 0, 0);
    push_item(OP_FINISH, 1, 16'hAAAA, 16'h5555, 16'hAAAA);
    push_item(OP_FINISH, 3, 0, 16'hFFFF, 0);
    push_item(OP_POLL, 1, 16'hFFFF, 0, 0);
    push_item(OP_FINISH, 2, 0, 16'hFFFF, 16'hFFFF);
    push_item(OP_POLL, 0, 16'hFFFE, 0, 0);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      src_idle = (mode == 0) ? 13 : (mode == 1) ? 56 : 0;
      snk_idle = (mode == 0) ? 56 : (mode == 1) ? 13 : 0;
      for (int k = 0; k < 5; k++) begin
        write_cfg(cfg_seq[k]);
        push_random(50);
        drain();
      end
    end

    if (grant_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", grant_q.size()));
    if (err_cnt == 0) begin
      $display("tb_tick_task_dispatcher_core: PASS");
    end else begin
      $display("tb_tick_task_dispatcher_core: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ttd_pkg.sv
design/ttd_ctrl.sv
design/ttd_datapath.sv
design/tick_task_dispatcher_core.sv
tb/sv/tb_tick_task_dispatcher_core.sv
